// ===== sv/rm2e_pkg.sv =====
package rm2e_pkg;

  // Datapath widths
  localparam int XW            = 35;  // CORDIC vector, input scaled by 2^16 plus gain headroom
  localparam int ZW            = 26;  // angle accumulator, degrees * 2^16
  localparam int CORDIC_STAGES = 16;
  localparam int SUM_W         = 32;  // r10^2 + r11^2
  localparam int ROOT_W        = 32;  // floor(sqrt(sum * 2^32))

  typedef logic signed [XW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // Angles in degrees * 2^16
  localparam ang_t DEG_45  = 26'sd2949120;
  localparam ang_t DEG_90  = 26'sd5898240;
  localparam ang_t DEG_135 = 26'sd8847360;
  localparam ang_t DEG_180 = 26'sd11796480;

  // atan(2^-i) in degrees * 2^16, rounded
  localparam ang_t ATAN_TAB [CORDIC_STAGES] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115
  };

endpackage

// ===== sv/rotation_matrix_to_euler_deg.sv =====
// Rotation matrix to Euler angles in degrees, fixed point.
// Input channel: in_valid / in_stall carries five Q2.14 matrix entries
// (r02, r22, r12, r10, r11); an item is taken on a clock edge with
// in_valid high and in_stall low.
// Output channel: out_valid / out_stall carries yaw, pitch and roll in
// degrees * 128, each saturated to its range; roll is folded into
// [-45, 45].
// Throughput: one item per cycle while in_stall is low. Pitch comes from
// the 32-stage square root of r10^2 + r11^2 followed by
// a 16-stage CORDIC; the yaw and roll CORDICs run alongside the pitch one
// behind a matching delay line.
// Stalls: the output register is backed by a one-item skid buffer. When
// the receiver stalls while a result waits, the next result lands in the
// skid buffer and in_stall rises as it fills, freezing the
// whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; the block holds no
// other state and is ready for an item on the first cycle after reset.
module rotation_matrix_to_euler_deg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] rot_r02,
  input  logic signed [15:0] rot_r22,
  input  logic signed [15:0] rot_r12,
  input  logic signed [15:0] rot_r10,
  input  logic signed [15:0] rot_r11,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] yaw_deg,
  output logic signed [14:0] pitch_deg,
  output logic signed [13:0] roll_deg
);
  import rm2e_pkg::*;

  localparam ang_t YAW_LIM   = 26'sd23040;
  localparam ang_t PITCH_LIM = 26'sd11520;
  localparam ang_t ROLL_LIM  = 26'sd5760;
  localparam ang_t HALF_LSB  = 26'sd256;

  function automatic vec_t scale(input logic signed [15:0] r);
    scale = {{(XW-32){r[15]}}, r, 16'h0000};
  endfunction

  function automatic logic signed [15:0] round_sat(input ang_t a, input ang_t lim);
    ang_t t;
    t = (a + HALF_LSB) >>> 9;
    if (t > lim) begin
      t = lim;
    end else if (t < -lim) begin
      t = -lim;
    end
    return t[15:0];
  endfunction

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // stage 0: capture entries and square r10, r11
  logic                     v0;
  logic signed [15:0]       r02_0, r22_0, r12_0, r10_0, r11_0;
  logic        [SUM_W-2:0]  sq10, sq11;
  logic signed [31:0]       p10, p11;

  assign p10 = rot_r10 * rot_r10;
  assign p11 = rot_r11 * rot_r11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r02_0 <= rot_r02;
      r22_0 <= rot_r22;
      r12_0 <= rot_r12;
      r10_0 <= rot_r10;
      r11_0 <= rot_r11;
      sq10  <= p10[SUM_W-2:0];
      sq11  <= p11[SUM_W-2:0];
    end
  end

  // stage 1: sum of squares
  logic             v1;
  logic [SUM_W-1:0] sq_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sum <= {1'b0, sq10} + {1'b0, sq11};
    end
  end

  // square root for the pitch denominator
  logic              v_root;
  logic [ROOT_W-1:0] root;

  rm2e_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .sq_sum    (sq_sum),
    .out_valid (v_root),
    .root      (root)
  );

  // matrix entries wait alongside the square root
  logic [79:0]        dly;
  logic signed [15:0] d02, d22, d12, d10, d11;

  rm2e_delay #(
    .WIDTH (80),
    .DEPTH (ROOT_W + 1)
  ) u_delay (
    .clk  (clk),
    .en   (en),
    .din  ({r02_0, r22_0, r12_0, r10_0, r11_0}),
    .dout (dly)
  );

  assign {d02, d22, d12, d10, d11} = dly;

  // three arctangents in parallel
  logic yaw_v, pitch_v, roll_v;
  ang_t yaw_a, pitch_a, roll_a;
  vec_t pitch_x;

  assign pitch_x = {{(XW-ROOT_W){1'b0}}, root};

  rm2e_cordic u_cordic_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_root),
    .y_in      (scale(d02)),
    .x_in      (scale(d22)),
    .out_valid (yaw_v),
    .angle     (yaw_a)
  );

  rm2e_cordic u_cordic_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_root),
    .y_in      (-scale(d12)),
    .x_in      (pitch_x),
    .out_valid (pitch_v),
    .angle     (pitch_a)
  );

  rm2e_cordic u_cordic_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_root),
    .y_in      (scale(d10)),
    .x_in      (scale(d11)),
    .out_valid (roll_v),
    .angle     (roll_a)
  );

  // yaw mapped onto the other half-turn, roll negated and folded
  ang_t yaw_n, roll_neg, roll_n;

  always_comb begin
    yaw_n    = yaw_a[ZW-1] ? -(DEG_180 + yaw_a) : (DEG_180 - yaw_a);
    roll_neg = -roll_a;
    roll_n   = roll_neg;
    if (roll_neg < -DEG_135) begin
      roll_n = roll_neg + DEG_180;
    end else if (roll_neg < -DEG_45) begin
      roll_n = roll_neg + DEG_90;
    end else if (roll_neg > DEG_135) begin
      roll_n = roll_neg - DEG_180;
    end else if (roll_neg > DEG_45) begin
      roll_n = roll_neg - DEG_90;
    end
  end

  logic vf;
  ang_t yaw_f, pitch_f, roll_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= pitch_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_f   <= yaw_n;
      pitch_f <= pitch_a;
      roll_f  <= roll_n;
    end
  end

  // round to 1/128 degree and saturate
  logic signed [15:0] yaw_s, pitch_s, roll_s;
  logic               vr;
  logic signed [15:0] yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [13:0] roll_r;

  assign yaw_s   = round_sat(yaw_f, YAW_LIM);
  assign pitch_s = round_sat(pitch_f, PITCH_LIM);
  assign roll_s  = round_sat(roll_f, ROLL_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= yaw_s;
      pitch_r <= pitch_s[14:0];
      roll_r  <= roll_s[13:0];
    end
  end

  // output register with one-item skid buffer
  logic               out_free;
  logic signed [15:0] skid_yaw;
  logic signed [14:0] skid_pitch;
  logic signed [13:0] skid_roll;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= vr;
    end else if (vr) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        yaw_deg   <= skid_yaw;
        pitch_deg <= skid_pitch;
        roll_deg  <= skid_roll;
      end
    end else if (out_free) begin
      yaw_deg   <= yaw_r;
      pitch_deg <= pitch_r;
      roll_deg  <= roll_r;
    end else begin
      skid_yaw   <= yaw_r;
      skid_pitch <= pitch_r;
      skid_roll  <= roll_r;
    end
  end

`ifndef SYNTHESIS
  // the three CORDIC lanes stay in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (yaw_v == pitch_v) && (roll_v == pitch_v))
    else $error("CORDIC lane valid bits disagree");

  // skid buffer only holds an item while the output is occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer full with empty output register");

  // skid buffer fills only after a stalled result
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid buffer filled without a stall");

  // results stay within their saturation ranges
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_deg <= 16'sd23040) && (yaw_deg >= -16'sd23040)
                  && (pitch_deg <= 15'sd11520) && (pitch_deg >= -15'sd11520)
                  && (roll_deg <= 14'sd5760) && (roll_deg >= -14'sd5760))
    else $error("result outside its range");
`endif

endmodule

// ===== sv/rm2e_delay.sv =====
module rm2e_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // shift line, advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== sv/rm2e_isqrt.sv =====
module rm2e_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rm2e_pkg::SUM_W-1:0]   sq_sum,
  output logic                         out_valid,
  output logic [rm2e_pkg::ROOT_W-1:0]  root
);
  import rm2e_pkg::*;

  // remainder needs two bits above the trial value {q, 01}
  localparam int RW = ROOT_W + 4;

  logic [RW-1:0]     rem [1:ROOT_W-1];
  logic [ROOT_W-1:0] q   [1:ROOT_W];
  logic [SUM_W-1:0]  sv  [1:SUM_W/2-1];
  logic              vld [1:ROOT_W];

  // one result bit per stage, radicand is sq_sum followed by 32 zero bits
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [RW-1:0]     rem_i, r2, t;
    logic [ROOT_W-1:0] q_i;
    logic              v_i, ge;
    logic [1:0]        pair;

    if (i == 0) begin : g_first
      assign rem_i = '0;
      assign q_i   = '0;
      assign v_i   = in_valid;
    end else begin : g_rest
      assign rem_i = rem[i];
      assign q_i   = q[i];
      assign v_i   = vld[i];
    end

    if (K >= SUM_W / 2) begin : g_pair
      if (i == 0) begin : g_p0
        assign pair = sq_sum[2*(K-SUM_W/2)+1 -: 2];
      end else begin : g_pn
        assign pair = sv[i][2*(K-SUM_W/2)+1 -: 2];
      end
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign r2 = {rem_i[RW-3:0], pair};
    assign t  = {{(RW-ROOT_W-2){1'b0}}, q_i, 2'b01};
    assign ge = (r2 >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= {q_i[ROOT_W-2:0], ge};
      end
    end

    if (i < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= ge ? (r2 - t) : r2;
        end
      end
    end

    if (i < SUM_W / 2 - 1) begin : g_sv
      if (i == 0) begin : g_s0
        always_ff @(posedge clk) begin
          if (en) begin
            sv[1] <= sq_sum;
          end
        end
      end else begin : g_sn
        always_ff @(posedge clk) begin
          if (en) begin
            sv[i+1] <= sv[i];
          end
        end
      end
    end
  end

  assign root      = q[ROOT_W];
  assign out_valid = vld[ROOT_W];

endmodule

// ===== sv/rm2e_cordic.sv =====
module rm2e_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  rm2e_pkg::vec_t y_in,
  input  rm2e_pkg::vec_t x_in,
  output logic           out_valid,
  output rm2e_pkg::ang_t angle
);
  import rm2e_pkg::*;

  vec_t xs   [0:CORDIC_STAGES];
  vec_t ys   [0:CORDIC_STAGES];
  ang_t zs   [0:CORDIC_STAGES];
  logic spec [0:CORDIC_STAGES];
  ang_t sval [0:CORDIC_STAGES];
  logic vld  [0:CORDIC_STAGES];

  vec_t pre_x, pre_y;
  ang_t pre_z, pre_sval, z_clamp;
  logic pre_spec;

  // axis cases bypass the iterations; left half-plane is turned by a quarter
  always_comb begin
    pre_x    = x_in;
    pre_y    = y_in;
    pre_z    = '0;
    pre_spec = 1'b0;
    pre_sval = '0;
    if (y_in == '0) begin
      pre_spec = 1'b1;
      pre_sval = x_in[XW-1] ? DEG_180 : '0;
    end else if (x_in == '0) begin
      pre_spec = 1'b1;
      pre_sval = y_in[XW-1] ? -DEG_90 : DEG_90;
    end else if (x_in[XW-1]) begin
      if (!y_in[XW-1]) begin
        pre_x = y_in;
        pre_y = -x_in;
        pre_z = DEG_90;
      end else begin
        pre_x = -y_in;
        pre_y = x_in;
        pre_z = -DEG_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= pre_x;
      ys[0]   <= pre_y;
      zs[0]   <= pre_z;
      spec[0] <= pre_spec;
      sval[0] <= pre_sval;
    end
  end

  // vectoring iterations, one per stage, drive y towards zero
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    vec_t x_sh, y_sh;
    assign x_sh = xs[i] >>> i;
    assign y_sh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][XW-1]) begin
          xs[i+1] <= xs[i] + y_sh;
          ys[i+1] <= ys[i] - x_sh;
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - y_sh;
          ys[i+1] <= ys[i] + x_sh;
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end
        spec[i+1] <= spec[i];
        sval[i+1] <= sval[i];
      end
    end
  end

  // clamp to a half turn either way
  always_comb begin
    z_clamp = zs[CORDIC_STAGES];
    if (z_clamp > DEG_180) begin
      z_clamp = DEG_180;
    end else if (z_clamp < -DEG_180) begin
      z_clamp = -DEG_180;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= spec[CORDIC_STAGES] ? sval[CORDIC_STAGES] : z_clamp;
    end
  end

endmodule
